@@ hw/rtl/gffc_pkg.sv @@
// Shared types and constants for the first-fit graph coloring block.
package gffc_pkg;

  // Graph capacity
  localparam int MaxNodes = 256;
  localparam int MaxEdges = 4096;

  // Field widths of the words
  localparam int KindW  = 2;
  localparam int FieldW = 13;
  localparam int NodeW  = $clog2(MaxNodes);
  localparam int CountW = 9;

  // Table geometry
  localparam int RowDepth = MaxNodes + 1;
  localparam int RowW     = $clog2(RowDepth);
  localparam int EdgeW    = $clog2(MaxEdges);

  // Free-color scan: colors checked per cycle
  localparam int ScanW      = 16;
  localparam int ScanLsb    = $clog2(ScanW);
  localparam int ScanChunks = MaxNodes / ScanW;
  localparam int ChunkW     = $clog2(ScanChunks);

  // Configuration register index (address bit 2)
  localparam logic RegNodeCount = 1'b0;

  typedef enum logic [KindW-1:0] {
    KindRowStart = 2'd0,
    KindNeighbor = 2'd1,
    KindColor    = 2'd2,
    KindClear    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [FieldW-1:0]  entry_index;
    logic [FieldW-1:0]  entry_value;
    logic [NodeW-1:0]   target_node;
  } gffc_in_t;

  typedef struct packed {
    logic [CountW-1:0]  assigned_color;
    logic               colored;
  } gffc_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StRdFirst,
    StRdLast,
    StRdEnd,
    StWalk,
    StScan,
    StFinish
  } state_e;

endpackage

@@ hw/rtl/greedy_first_fit_coloring.sv @@
// Operation: table writes and clears are taken in the idle state; a color request
//   runs a row lookup, a neighbor walk at one edge per cycle through the neighbor
//   memory, a drain and a 16-color scan, then a finish step.
// Throughput: one word at a time; the next word is taken once the previous one
//   is done, while a result may still wait in the output register.
// Reset: control cleared, every node uncolored, node_count = 256. The row-start
//   and neighbor tables are undefined until loaded; no clearing pass is run.
module greedy_first_fit_coloring import gffc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  gffc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output gffc_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q, state_d;

  logic [CountW-1:0]  node_count_q;
  logic [CountW-1:0]  cnt;
  logic [NodeW-1:0]   node_q;
  logic [FieldW-1:0]  e_q;
  logic [FieldW-1:0]  last_q;
  logic               p1_q, p2_q;
  logic [ChunkW-1:0]  chunk_q;
  logic [CountW-1:0]  res_color_q;
  logic               res_ok_q;
  logic               out_valid_q;
  gffc_out_t          out_q;
  logic [MaxNodes-1:0] valid_q;
  logic [MaxNodes-1:0] forb_q;

  // Memories and their registered read data
  logic [FieldW-1:0] row_mem [RowDepth];
  logic [FieldW-1:0] nb_mem  [MaxEdges];
  logic [NodeW-1:0]  col_mem [MaxNodes];
  logic [FieldW-1:0] rs_rd_q;
  logic [FieldW-1:0] nb_rd_q;
  logic [NodeW-1:0]  col_rd_q;

  // Control
  logic              accept;
  logic              in_range;
  logic [RowW-1:0]   rs_addr;
  logic              nb_rd_en;
  logic              hit1;
  logic              mark;
  logic              finish_ok;
  logic              cfg_we;
  logic [FieldW-1:0] last_clip;

  // Scan
  logic [NodeW-1:0]  base;
  logic [NodeW-1:0]  cand;
  logic [ScanLsb-1:0] hit_idx;
  logic              found;
  logic              scan_last;

  // Effective node count, saturated to capacity
  assign cnt = (node_count_q > CountW'(MaxNodes)) ? CountW'(MaxNodes) : node_count_q;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegNodeCount);
  assign prdata = (paddr[2] == RegNodeCount) ? 32'(node_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountW'(MaxNodes);
    end else if (cfg_we) begin
      node_count_q <= pwdata[CountW-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && in_data_i.kind == KindColor) begin
          state_d = in_range ? StRdFirst : StFinish;
        end
      end
      StRdFirst: state_d = StRdLast;
      StRdLast:  state_d = StRdEnd;
      StRdEnd:   state_d = StWalk;
      StWalk: begin
        if (!nb_rd_en && !p1_q && !p2_q) state_d = StScan;
      end
      StScan: begin
        if (found || scan_last) state_d = StFinish;
      end
      StFinish: begin
        if (finish_ok) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o = (state_q == StIdle);
    accept     = in_valid_i && in_ready_o;
    in_range   = CountW'(in_data_i.target_node) < cnt;
    rs_addr    = (state_q == StRdFirst) ? RowW'(node_q) : RowW'(node_q) + RowW'(1);
    nb_rd_en   = (state_q == StWalk) && (e_q < last_q);
    hit1       = p1_q && (nb_rd_q < FieldW'(cnt)) && valid_q[nb_rd_q[NodeW-1:0]];
    mark       = p2_q && (CountW'(col_rd_q) < cnt);
    finish_ok  = (state_q == StFinish) && (!out_valid_q || out_ready_i);
    last_clip  = (rs_rd_q > FieldW'(MaxEdges)) ? FieldW'(MaxEdges) : rs_rd_q;
  end

  // First free color in the current chunk of 16
  always_comb begin
    base      = {chunk_q, {ScanLsb{1'b0}}};
    found     = 1'b0;
    hit_idx   = '0;
    cand      = '0;
    for (int j = ScanW - 1; j >= 0; j--) begin
      cand = base + NodeW'(j);
      if (!forb_q[cand] && (CountW'(cand) < cnt)) begin
        found   = 1'b1;
        hit_idx = ScanLsb'(j);
      end
    end
    scan_last = (chunk_q == ChunkW'(ScanChunks - 1)) ||
                ((CountW'(base) + CountW'(ScanW)) >= cnt);
  end

  // State and request control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q <= state_d;
      p1_q    <= nb_rd_en;
      p2_q    <= hit1;
      if (accept && in_data_i.kind == KindClear) begin
        valid_q <= '0;
      end else if (finish_ok && res_ok_q) begin
        valid_q[node_q] <= 1'b1;
      end
      if (finish_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request datapath
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.kind == KindColor) begin
      node_q      <= in_data_i.target_node;
      chunk_q     <= '0;
      res_color_q <= cnt;
      res_ok_q    <= 1'b0;
    end
    if (state_q == StRdLast) e_q <= rs_rd_q;
    if (state_q == StRdEnd) last_q <= last_clip;
    if (nb_rd_en) e_q <= e_q + FieldW'(1);
    if (state_q == StScan) begin
      if (found) begin
        res_color_q <= CountW'(base) + CountW'(hit_idx);
        res_ok_q    <= 1'b1;
      end else if (!scan_last) begin
        chunk_q <= chunk_q + ChunkW'(1);
      end
    end
    if (finish_ok) begin
      out_q.assigned_color <= res_color_q;
      out_q.colored        <= res_ok_q;
    end
  end

  // Forbidden-color marks: cleared at request start, set by the walk
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.kind == KindColor) begin
      forb_q <= '0;
    end else if (mark) begin
      forb_q[col_rd_q] <= 1'b1;
    end
  end

  // Row-start memory
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.kind == KindRowStart &&
        in_data_i.entry_index <= FieldW'(MaxNodes)) begin
      row_mem[in_data_i.entry_index[RowW-1:0]] <= in_data_i.entry_value;
    end
    rs_rd_q <= row_mem[rs_addr];
  end

  // Neighbor memory
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.kind == KindNeighbor &&
        in_data_i.entry_index < FieldW'(MaxEdges)) begin
      nb_mem[in_data_i.entry_index[EdgeW-1:0]] <= in_data_i.entry_value;
    end
    if (nb_rd_en) nb_rd_q <= nb_mem[e_q[EdgeW-1:0]];
  end

  // Node color memory: written at request end, read during the walk
  always_ff @(posedge clk_i) begin
    if (finish_ok && res_ok_q) begin
      col_mem[node_q] <= res_color_q[NodeW-1:0];
    end
    col_rd_q <= col_mem[nb_rd_q[NodeW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/gffc_checker.sv @@
// Port-level assertions for the first-fit graph coloring block, with bind.
module gffc_checker import gffc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input gffc_in_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input gffc_out_t   out_data_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata
);

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] eff;

  // Shadow of the node count as written on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(MaxNodes);
    end else if (psel && penable && pwrite && paddr[2] == RegNodeCount) begin
      count_q <= pwdata[CountW-1:0];
    end
  end

  assign eff = (count_q > CountW'(MaxNodes)) ? CountW'(MaxNodes) : count_q;

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Table writes and clears return to ready in the next cycle
  a_short_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind != KindColor |=> in_ready_o)
    else $error("non-color word did not return to ready");

  // A failure reports the effective node count
  a_fail_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.colored |-> out_data_o.assigned_color == eff)
    else $error("failure word carries wrong color");

  // A success reports a color below the node count
  a_ok_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.colored |-> out_data_o.assigned_color < eff)
    else $error("assigned color out of range");

endmodule

bind greedy_first_fit_coloring gffc_checker u_gffc_checker (.*);
